// ===== design/bcp_pkg.sv =====
// ----------------------------------------------------------------------------
// Bezier curve point package
// Shared types, widths and constants for the de Casteljau point pipeline.
// ----------------------------------------------------------------------------
package bcp_pkg;

    localparam int COORD_W    = 32;
    localparam int PARAM_W    = 17;
    localparam int NUM_PTS    = 4;
    localparam int NUM_STAGES = 6;

    // Input payload: eight coordinates followed by the parameter, padded to bytes.
    localparam int S_TDATA_RAW = 2 * NUM_PTS * COORD_W + PARAM_W;
    localparam int S_TDATA_W   = ((S_TDATA_RAW + 7) / 8) * 8;
    localparam int M_TDATA_W   = 2 * COORD_W;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic        [PARAM_W-1:0] param_t;

    // A parameter of exactly one in Q1.16.
    localparam param_t PARAM_ONE = param_t'(1 << (PARAM_W - 1));

    // Per-stage load strobes from the flow control to the datapath.
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } stage_ctl_t;

endpackage

// ===== design/bcp_lerp.sv =====
// ----------------------------------------------------------------------------
// Bezier curve point: pipelined linear interpolation
// Computes a + floor(t * (b - a) / 65536) over two register stages:
// difference and product first, then the add.
// ----------------------------------------------------------------------------
module bcp_lerp (
    input  logic            aclk,
    input  logic            ld_mul,
    input  logic            ld_add,
    input  bcp_pkg::param_t t,
    input  bcp_pkg::coord_t a,
    input  bcp_pkg::coord_t b,
    output bcp_pkg::coord_t y
);
    import bcp_pkg::*;

    logic signed [COORD_W:0]     diff;
    logic signed [COORD_W+18:0]  prod;
    logic signed [COORD_W+1:0]   q_reg;
    logic signed [COORD_W+1:0]   sum;
    coord_t                      a_reg;
    coord_t                      y_reg;

    assign diff = {b[COORD_W-1], b} - {a[COORD_W-1], a};
    assign prod = $signed({1'b0, t}) * diff;

    // The product fits in 50 bits, so taking bits above 16 is the floor shift.
    always_ff @(posedge aclk) begin
        if (ld_mul) begin
            a_reg <= a;
            q_reg <= prod[COORD_W+17:16];
        end
    end

    assign sum = {{2{a_reg[COORD_W-1]}}, a_reg} + q_reg;

    always_ff @(posedge aclk) begin
        if (ld_add) begin
            y_reg <= sum[COORD_W-1:0];
        end
    end

    assign y = y_reg;

endmodule

// ===== design/bcp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Bezier curve point: pipeline flow control
// Valid bits for each stage and a ready chain so that bubbles are squeezed
// out and a stalled output holds without losing or repeating a transaction.
// ----------------------------------------------------------------------------
module bcp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output bcp_pkg::stage_ctl_t ctl
);
    import bcp_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES:0]   ready;

    always_comb begin
        ready[NUM_STAGES] = m_tready;
        for (int i = NUM_STAGES - 1; i >= 0; i--) begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
    end

    always_comb begin
        valid_next  = valid_reg;
        ctl.load[0] = ready[0] && s_tvalid;
        if (ready[0]) begin
            valid_next[0] = s_tvalid;
        end
        for (int i = 1; i < NUM_STAGES; i++) begin
            ctl.load[i] = ready[i] && valid_reg[i-1];
            if (ready[i]) begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = ready[0];
    assign m_tvalid = valid_reg[NUM_STAGES-1];

    a_full_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        ((&valid_reg) && !m_tready) |-> !s_tready)
        else $error("input accepted while every stage is full and stalled");

    a_accept_fills_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> valid_reg[0])
        else $error("accepted transaction did not enter the first stage");

    a_stalled_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[NUM_STAGES-2] && !ready[NUM_STAGES-2]) |=> valid_reg[NUM_STAGES-2])
        else $error("stalled stage lost its transaction");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

// ===== design/bezier_curve_point_unit.sv =====
// Throughput: one point per cycle unless the output stalls; six lerp stages (three levels
// of multiply then add), and every stage holds its own transaction.
// Reset clears only the stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// Bezier curve point unit
// Evaluates one point of a quadratic or cubic 2D Bezier curve by three levels
// of de Casteljau interpolation. Quadratic items pass the first level with t = 0.
// ----------------------------------------------------------------------------
module bezier_curve_point_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, param, zero padding
    input  logic [bcp_pkg::S_TDATA_W-1:0]  s_tdata,
    // kind
    input  logic [0:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // point_x, point_y
    output logic [bcp_pkg::M_TDATA_W-1:0]  m_tdata
);
    import bcp_pkg::*;

    stage_ctl_t ctl;
    coord_t     in_x [NUM_PTS];
    coord_t     in_y [NUM_PTS];
    coord_t     la_x [3];
    coord_t     la_y [3];
    coord_t     lb_x [2];
    coord_t     lb_y [2];
    coord_t     lc_x;
    coord_t     lc_y;
    param_t     s_param;
    param_t     t_in;
    param_t     t_first;
    param_t     t1_reg;
    param_t     t2_reg;
    param_t     t3_reg;
    param_t     t4_reg;

    bcp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctl      (ctl)
    );

    always_comb begin
        for (int i = 0; i < NUM_PTS; i++) begin
            in_x[i] = s_tdata[2*i*COORD_W +: COORD_W];
            in_y[i] = s_tdata[(2*i+1)*COORD_W +: COORD_W];
        end
    end

    assign s_param = s_tdata[2*NUM_PTS*COORD_W +: PARAM_W];

    // Anything at or above one clamps to one.
    assign t_in    = s_param[PARAM_W-1] ? PARAM_ONE : s_param;
    // A zero parameter makes the first level pass p0, p1, p2 through unchanged.
    assign t_first = s_tuser[0] ? t_in : '0;

    always_ff @(posedge aclk) begin
        if (ctl.load[0]) t1_reg <= t_in;
        if (ctl.load[1]) t2_reg <= t1_reg;
        if (ctl.load[2]) t3_reg <= t2_reg;
        if (ctl.load[3]) t4_reg <= t3_reg;
    end

    for (genvar j = 0; j < 3; j++) begin : g_lvl_a
        bcp_lerp u_lerp_x (
            .aclk (aclk), .ld_mul (ctl.load[0]), .ld_add (ctl.load[1]),
            .t (t_first), .a (in_x[j]), .b (in_x[j+1]), .y (la_x[j])
        );
        bcp_lerp u_lerp_y (
            .aclk (aclk), .ld_mul (ctl.load[0]), .ld_add (ctl.load[1]),
            .t (t_first), .a (in_y[j]), .b (in_y[j+1]), .y (la_y[j])
        );
    end

    for (genvar j = 0; j < 2; j++) begin : g_lvl_b
        bcp_lerp u_lerp_x (
            .aclk (aclk), .ld_mul (ctl.load[2]), .ld_add (ctl.load[3]),
            .t (t2_reg), .a (la_x[j]), .b (la_x[j+1]), .y (lb_x[j])
        );
        bcp_lerp u_lerp_y (
            .aclk (aclk), .ld_mul (ctl.load[2]), .ld_add (ctl.load[3]),
            .t (t2_reg), .a (la_y[j]), .b (la_y[j+1]), .y (lb_y[j])
        );
    end

    bcp_lerp u_lvl_c_x (
        .aclk (aclk), .ld_mul (ctl.load[4]), .ld_add (ctl.load[5]),
        .t (t4_reg), .a (lb_x[0]), .b (lb_x[1]), .y (lc_x)
    );

    bcp_lerp u_lvl_c_y (
        .aclk (aclk), .ld_mul (ctl.load[4]), .ld_add (ctl.load[5]),
        .t (t4_reg), .a (lb_y[0]), .b (lb_y[1]), .y (lc_y)
    );

    assign m_tdata = {lc_y, lc_x};

endmodule

// ===== tb/bezier_curve_point_unit_test.sv =====
// ----------------------------------------------------------------------------
// Bezier curve point unit testbench
// Sends quadratic and cubic control point sets with a curve parameter into the
// unit and checks every returned point against an in-order scoreboard. Both
// stream sides idle at random, with bursts that run without gaps.
// ----------------------------------------------------------------------------
module bezier_curve_point_unit_test;

    import bcp_pkg::*;

    localparam int  RANDOM_ITEMS = 600;
    localparam int  DRAIN_CYCLES = 24;
    localparam int  PTS_W        = 2 * NUM_PTS * COORD_W;
    localparam logic KIND_QUAD   = 1'b0;
    localparam logic KIND_CUBIC  = 1'b1;

    // Holds the curve points still owed by the unit, oldest first.
    class curve_point_book;
        logic [M_TDATA_W-1:0] expected_points[$];
        int mismatches;
        int points_checked;

        function new();
            mismatches     = 0;
            points_checked = 0;
        endfunction

        // One interpolation step: a + floor(t * (b - a) / 2^16).
        function longint interp(longint a, longint b, longint t);
            longint prod;
            prod = t * (b - a);
            return a + (prod >>> 16);
        endfunction

        function longint eval_coord(logic cubic, longint a, longint b, longint c,
                                    longint d, longint t);
            longint qa, qb, qc;
            if (cubic) begin
                qa = interp(a, b, t);
                qb = interp(b, c, t);
                qc = interp(c, d, t);
            end else begin
                qa = a;
                qb = b;
                qc = c;
            end
            return interp(interp(qa, qb, t), interp(qb, qc, t), t);
        endfunction

        function void note_input(logic [S_TDATA_W-1:0] data, logic kind);
            coord_t  c[2*NUM_PTS];
            param_t  t;
            longint  px, py;
            for (int j = 0; j < 2 * NUM_PTS; j++) begin
                c[j] = data[j*COORD_W +: COORD_W];
            end
            t = data[PTS_W +: PARAM_W];
            if (t > PARAM_ONE) begin
                t = PARAM_ONE;
            end
            px = eval_coord(kind == KIND_CUBIC, c[0], c[2], c[4], c[6], longint'(t));
            py = eval_coord(kind == KIND_CUBIC, c[1], c[3], c[5], c[7], longint'(t));
            expected_points.push_back({py[COORD_W-1:0], px[COORD_W-1:0]});
        endfunction

        function void check_point(logic [M_TDATA_W-1:0] got);
            logic [M_TDATA_W-1:0] want;
            if (expected_points.size() == 0) begin
                $display("%0t: unexpected result transaction, actual %h", $time, got);
                mismatches++;
                return;
            end
            want = expected_points.pop_front();
            points_checked++;
            if (got[COORD_W-1:0] !== want[COORD_W-1:0]) begin
                $display("%0t: point_x mismatch, expected %h actual %h", $time,
                         want[COORD_W-1:0], got[COORD_W-1:0]);
                mismatches++;
            end
            if (got[M_TDATA_W-1:COORD_W] !== want[M_TDATA_W-1:COORD_W]) begin
                $display("%0t: point_y mismatch, expected %h actual %h", $time,
                         want[M_TDATA_W-1:COORD_W], got[M_TDATA_W-1:COORD_W]);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_points.size();
        endfunction
    endclass

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic [0:0]            s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    curve_point_book book = new();

    bit     no_idle = 1'b0;
    int     quad_sent, cubic_sent, clamped_sent;
    param_t corner_params[7] = '{17'd0, 17'd1, 17'd32768, 17'd65535, 17'd65536,
                                 17'd65537, 17'd131071};

    bezier_curve_point_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    // Both channels are sampled at the edge, before any of this edge's updates land.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                book.check_point(m_tdata);
            end
            if (s_tvalid && s_tready) begin
                book.note_input(s_tdata, s_tuser[0]);
            end
        end
    end

    function automatic coord_t corner_coord(int sel);
        case (sel % 4)
            0: return coord_t'(32'h7FFF_FFFF);
            1: return coord_t'(32'h8000_0000);
            2: return coord_t'(32'h0000_0000);
            default: return coord_t'(32'hFFFF_FFFF);
        endcase
    endfunction

    function automatic coord_t random_coord();
        case ($urandom_range(0, 7))
            0: return corner_coord($urandom_range(0, 3));
            1, 2: return coord_t'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic param_t random_param();
        case ($urandom_range(0, 9))
            0: return param_t'(0);
            1: return PARAM_ONE;
            2: return param_t'($urandom_range(65537, 131071));
            default: return param_t'($urandom_range(0, 65536));
        endcase
    endfunction

    // Presents one item and returns at the edge where its transaction completes.
    task automatic send_curve(input logic kind, input logic [PTS_W-1:0] pts,
                              input param_t t);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(S_TDATA_W - S_TDATA_RAW){1'b0}}, t, pts};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (kind == KIND_CUBIC) cubic_sent++;
        else quad_sent++;
        if (t > PARAM_ONE) clamped_sent++;
    endtask

    task automatic send_random_curve();
        logic [PTS_W-1:0] pts;
        for (int j = 0; j < 2 * NUM_PTS; j++) begin
            pts[j*COORD_W +: COORD_W] = random_coord();
        end
        send_curve($urandom_range(0, 1) ? KIND_CUBIC : KIND_QUAD, pts, random_param());
    endtask

    // Result side: a random stall before each result, none during bursts.
    initial begin
        int stall;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(aresetn && m_tvalid)) @(posedge aclk);
        end
    end

    initial begin
        #4000000;
        $display("bezier_curve_point_unit_test failed");
        $finish;
    end

    initial begin
        logic [PTS_W-1:0] pts;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Parameter corners, including values above one, on both curve kinds
        // with coordinates at the extremes of the signed range.
        for (int i = 0; i < 14; i++) begin
            for (int j = 0; j < 2 * NUM_PTS; j++) begin
                pts[j*COORD_W +: COORD_W] = corner_coord(i + j + (j / 2));
            end
            send_curve(i[0] ? KIND_CUBIC : KIND_QUAD, pts, corner_params[i / 2]);
        end
        // The endpoints of random curves: the result must equal p0 or the end point.
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 2 * NUM_PTS; j++) begin
                pts[j*COORD_W +: COORD_W] = coord_t'($urandom);
            end
            send_curve(i[0] ? KIND_CUBIC : KIND_QUAD, pts, i[1] ? PARAM_ONE : param_t'(0));
        end
        // Quadratic items whose unused p3 is at opposite extremes.
        pts = '0;
        pts[6*COORD_W +: 2*COORD_W] = {2{32'h7FFF_FFFF}};
        send_curve(KIND_QUAD, pts, param_t'(40000));
        pts[6*COORD_W +: 2*COORD_W] = {2{32'h8000_0000}};
        send_curve(KIND_QUAD, pts, param_t'(40000));

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 60 == 0) begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            send_random_curve();
        end
        s_tvalid <= 1'b0;
        no_idle = 1'b0;

        while (book.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d quadratic and %0d cubic curves, %0d with the parameter above one.",
                 quad_sent, cubic_sent, clamped_sent);
        $display("Checked %0d curve points, %0d mismatches.",
                 book.points_checked, book.mismatches);
        if (book.mismatches == 0) begin
            $display("bezier_curve_point_unit_test passed");
        end else begin
            $display("bezier_curve_point_unit_test failed");
        end
        $finish;
    end

endmodule
